// ===== rtl/periodic_task_tick_scheduler_unit_defines.svh =====
// Assertion macros shared by the scheduler checker.
// No dependencies; included by files that assert.
`ifndef PERIODIC_TASK_TICK_SCHEDULER_UNIT_DEFINES_SVH
`define PERIODIC_TASK_TICK_SCHEDULER_UNIT_DEFINES_SVH

// same-cycle implication, disabled in reset
`define PTTS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("scheduler check failed");

// next-cycle implication, disabled in reset
`define PTTS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("scheduler check failed");

`endif

// ===== rtl/ptts_pkg.sv =====
// Shared types and constants of the periodic task tick scheduler.
// No dependencies.
package ptts_pkg;

	localparam int TASK_COUNT = 8;
	localparam int ID_W = (TASK_COUNT > 1) ? $clog2(TASK_COUNT) : 1;
	localparam int MASK_N = (TASK_COUNT < 8) ? TASK_COUNT : 8;

	localparam logic [2:0] CMD_INIT     = 3'd0;
	localparam logic [2:0] CMD_CREATE   = 3'd1;
	localparam logic [2:0] CMD_TICK     = 3'd2;
	localparam logic [2:0] CMD_WAKE     = 3'd3;
	localparam logic [2:0] CMD_SLEEP    = 3'd4;
	localparam logic [2:0] CMD_DISPATCH = 3'd5;

	localparam logic [1:0] ST_DONE    = 2'd0;
	localparam logic [1:0] ST_IGNORED = 2'd1;
	localparam logic [1:0] ST_EMPTY   = 2'd2;

	typedef struct packed {
		logic [2:0]  cmd;
		logic [2:0]  task_id;
		logic [15:0] period;
	} ptts_req_t;

	typedef struct packed {
		logic [1:0] status;
		logic [2:0] chosen_task;
		logic [7:0] due_mask;
		logic [7:0] pending_mask;
	} ptts_rsp_t;

endpackage

// ===== rtl/periodic_task_tick_scheduler_unit.sv =====
// Periodic task tick scheduler, top level: request register, slot table, result register.
// Depends on ptts_pkg and ptts_slot_table.
//
//   channel | handshake            | payload
//   --------+----------------------+-------------------------------
//   req     | req_valid/req_ready  | ptts_req_t: cmd, task_id, period
//   rsp     | rsp_valid/rsp_ready  | ptts_rsp_t: status, chosen_task, masks
//
// One item per cycle while the result is not stalled; each item passes the request register, then the result register.
// The slot table executes the command combinationally between the request
// register and the result register, so the next item sees the updated slots.
// Reset clears created, pending and scan pointer; period and count need none.
// A stalled result holds the request stage; req_ready falls only when both are full.
module periodic_task_tick_scheduler_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  ptts_pkg::ptts_req_t req,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output ptts_pkg::ptts_rsp_t rsp
);

	ptts_pkg::ptts_req_t item_s1;
	logic                valid_s1;
	ptts_pkg::ptts_rsp_t rsp_q;
	logic                rsp_valid_q;
	ptts_pkg::ptts_rsp_t result;
	logic                adv;
	logic                req_fire;

	assign adv       = valid_s1 && (!rsp_valid_q || rsp_ready);
	assign req_ready = !valid_s1 || adv;
	assign req_fire  = req_valid && req_ready;

	ptts_slot_table u_table (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (adv),
		.item   (item_s1),
		.result (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			valid_s1    <= req_fire || (valid_s1 && !adv);
			rsp_valid_q <= adv || (rsp_valid_q && !rsp_ready);
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire) begin
			item_s1 <= req;
		end
		if (adv) begin
			rsp_q <= result;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// ===== rtl/ptts_rr_pick.sv =====
// Round-robin pick of the first pending slot at or after the scan pointer, else the lowest pending slot.
// Depends on ptts_pkg.
module ptts_rr_pick (
	input  logic [ptts_pkg::TASK_COUNT-1:0] pending,
	input  logic [ptts_pkg::ID_W-1:0]       ptr,
	output logic                            found,
	output logic [ptts_pkg::ID_W-1:0]       idx
);

	logic                      hi_found;
	logic [ptts_pkg::ID_W-1:0] hi_idx;
	logic [ptts_pkg::ID_W-1:0] lo_idx;

	// walk downward so the lowest matching slot wins
	always_comb begin
		hi_found = 1'b0;
		hi_idx   = '0;
		lo_idx   = '0;
		for (int i = ptts_pkg::TASK_COUNT - 1; i >= 0; i--) begin
			if (pending[i]) begin
				lo_idx = ptts_pkg::ID_W'(i);
				if (i >= int'(ptr)) begin
					hi_found = 1'b1;
					hi_idx   = ptts_pkg::ID_W'(i);
				end
			end
		end
	end

	assign found = |pending;
	assign idx   = hi_found ? hi_idx : lo_idx;

endmodule

// ===== rtl/ptts_slot_table.sv =====
// Task slot table: slot state, tick counters and command execution.
// Depends on ptts_pkg and ptts_rr_pick.
module ptts_slot_table (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                fire,
	input  ptts_pkg::ptts_req_t item,
	output ptts_pkg::ptts_rsp_t result
);

	localparam int N = ptts_pkg::TASK_COUNT;
	localparam int W = ptts_pkg::ID_W;

	logic [N-1:0]  created_q;
	logic [N-1:0]  pending_q;
	logic [W-1:0]  ptr_q;
	logic [15:0]   period_q  [N];
	logic [15:0]   elapsed_q [N];

	logic [N-1:0]  created_d;
	logic [N-1:0]  pending_d;
	logic [W-1:0]  ptr_d;
	logic [16:0]   next_cnt  [N];
	logic [N-1:0]  due_hit;
	logic [N-1:0]  due_d;
	logic          create_en;
	logic          tick_en;
	logic          in_range;
	logic [W-1:0]  idx;
	logic [1:0]    status_d;
	logic [2:0]    chosen_d;
	logic          pick_found;
	logic [W-1:0]  pick_idx;

	assign in_range = 32'(item.task_id) < N;
	assign idx      = W'(32'(item.task_id));

	ptts_rr_pick u_pick (
		.pending (pending_q),
		.ptr     (ptr_q),
		.found   (pick_found),
		.idx     (pick_idx)
	);

	always_comb begin
		for (int i = 0; i < N; i++) begin
			next_cnt[i] = {1'b0, elapsed_q[i]} + 17'd1;
			due_hit[i]  = created_q[i] && (next_cnt[i] >= {1'b0, period_q[i]});
		end
	end

	always_comb begin
		created_d = created_q;
		pending_d = pending_q;
		ptr_d     = ptr_q;
		due_d     = '0;
		create_en = 1'b0;
		tick_en   = 1'b0;
		status_d  = ptts_pkg::ST_DONE;
		chosen_d  = '0;
		unique case (item.cmd)
			ptts_pkg::CMD_INIT: begin
				created_d = '0;
				pending_d = '0;
				ptr_d     = '0;
			end
			ptts_pkg::CMD_CREATE: begin
				if (!in_range || created_q[idx]) begin
					status_d = ptts_pkg::ST_IGNORED;
				end else begin
					created_d[idx] = 1'b1;
					pending_d[idx] = 1'b0;
					create_en      = 1'b1;
				end
			end
			ptts_pkg::CMD_TICK: begin
				tick_en   = 1'b1;
				due_d     = due_hit;
				pending_d = pending_q | due_hit;
			end
			ptts_pkg::CMD_WAKE: begin
				if (!in_range || !created_q[idx]) begin
					status_d = ptts_pkg::ST_IGNORED;
				end else begin
					pending_d[idx] = 1'b1;
				end
			end
			ptts_pkg::CMD_SLEEP: begin
				if (!in_range) begin
					status_d = ptts_pkg::ST_IGNORED;
				end else begin
					pending_d[idx] = 1'b0;
				end
			end
			ptts_pkg::CMD_DISPATCH: begin
				if (pick_found) begin
					pending_d[pick_idx] = 1'b0;
					chosen_d            = 3'(pick_idx);
					ptr_d = (pick_idx == W'(N - 1)) ? '0 : pick_idx + W'(1);
				end else begin
					status_d = ptts_pkg::ST_EMPTY;
				end
			end
			default: begin
				status_d = ptts_pkg::ST_IGNORED;
			end
		endcase
	end

	always_comb begin
		result              = '0;
		result.status       = status_d;
		result.chosen_task  = chosen_d;
		for (int i = 0; i < ptts_pkg::MASK_N; i++) begin
			result.due_mask[i]     = due_d[i];
			result.pending_mask[i] = pending_d[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			created_q <= '0;
			pending_q <= '0;
			ptr_q     <= '0;
		end else if (fire) begin
			created_q <= created_d;
			pending_q <= pending_d;
			ptr_q     <= ptr_d;
		end
	end

	// period and count are only read for created slots, so no reset
	always_ff @(posedge clk) begin
		for (int i = 0; i < N; i++) begin
			if (fire && create_en && (idx == W'(i))) begin
				period_q[i]  <= item.period;
				elapsed_q[i] <= '0;
			end else if (fire && tick_en && created_q[i]) begin
				elapsed_q[i] <= due_hit[i] ? 16'd0 : next_cnt[i][15:0];
			end
		end
	end

endmodule

// ===== rtl/ptts_checker.sv =====
// Port-level checks of the scheduler top level, attached by bind.
// Depends on ptts_pkg and periodic_task_tick_scheduler_unit_defines.svh.
`include "periodic_task_tick_scheduler_unit_defines.svh"

module ptts_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                req_valid,
	input logic                req_ready,
	input ptts_pkg::ptts_req_t req,
	input logic                rsp_valid,
	input logic                rsp_ready,
	input ptts_pkg::ptts_rsp_t rsp
);

	logic rsp_not_done;
	logic rsp_clean;

	assign rsp_not_done = rsp_valid && (rsp.status != ptts_pkg::ST_DONE);
	assign rsp_clean    = (rsp.chosen_task == 3'd0) && (rsp.due_mask == 8'd0);

	`PTTS_ASSERT_NEXT(a_req_hold, clk, arst_n, req_valid && !req_ready, req_valid && $stable(req))
	`PTTS_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp))
	`PTTS_ASSERT_NOW(a_status_code, clk, arst_n, rsp_valid, rsp.status <= ptts_pkg::ST_EMPTY)
	`PTTS_ASSERT_NOW(a_not_done_clean, clk, arst_n, rsp_not_done, rsp_clean)
	`PTTS_ASSERT_NOW(a_due_is_pending, clk, arst_n, rsp_valid, (rsp.due_mask & ~rsp.pending_mask) == 8'd0)

endmodule

bind periodic_task_tick_scheduler_unit ptts_checker u_ptts_checker (.*);

// ===== bench/ptts_slot_tracker_pkg.sv =====
// Slot-table tracker for the periodic task tick scheduler bench: mirrors the slot
// state, predicts each result and compares it with what the block returns.
// Depends on ptts_pkg.
`timescale 1ns / 100ps

package ptts_slot_tracker_pkg;

	import ptts_pkg::*;

	class slot_table_tracker;

		bit          created [TASK_COUNT];
		bit [15:0]   period_of [TASK_COUNT];
		bit [15:0]   elapsed [TASK_COUNT];
		bit          pending [TASK_COUNT];
		int unsigned scan_ptr;
		ptts_rsp_t   awaited_rsps [$];
		int unsigned mismatches;

		function void clear_slots();
			for (int i = 0; i < TASK_COUNT; i++) begin
				created[i] = 1'b0;
				period_of[i] = '0;
				elapsed[i] = '0;
				pending[i] = 1'b0;
			end
			scan_ptr = 0;
		endfunction

		// apply one accepted command and queue the result it must produce
		function void note_command(ptts_req_t c);
			ptts_rsp_t   e;
			int unsigned slot;
			int unsigned next_count;
			bit          found;
			e = '0;
			e.status = ST_DONE;
			found = 1'b0;
			case (c.cmd)
				CMD_INIT: begin
					clear_slots();
				end
				CMD_CREATE: begin
					if (c.task_id >= TASK_COUNT || created[c.task_id]) begin
						e.status = ST_IGNORED;
					end else begin
						created[c.task_id] = 1'b1;
						period_of[c.task_id] = c.period;
						elapsed[c.task_id] = '0;
						pending[c.task_id] = 1'b0;
					end
				end
				CMD_TICK: begin
					for (int i = 0; i < TASK_COUNT; i++) begin
						if (created[i]) begin
							next_count = elapsed[i] + 1;
							if (next_count >= period_of[i]) begin
								elapsed[i] = '0;
								pending[i] = 1'b1;
								if (i < 8)
									e.due_mask[i] = 1'b1;
							end else begin
								elapsed[i] = next_count[15:0];
							end
						end
					end
				end
				CMD_WAKE: begin
					if (c.task_id >= TASK_COUNT || !created[c.task_id])
						e.status = ST_IGNORED;
					else
						pending[c.task_id] = 1'b1;
				end
				CMD_SLEEP: begin
					if (c.task_id >= TASK_COUNT)
						e.status = ST_IGNORED;
					else
						pending[c.task_id] = 1'b0;
				end
				CMD_DISPATCH: begin
					for (int k = 0; k < TASK_COUNT && !found; k++) begin
						slot = (scan_ptr + k) % TASK_COUNT;
						if (pending[slot]) begin
							pending[slot] = 1'b0;
							e.chosen_task = slot[2:0];
							scan_ptr = (slot + 1) % TASK_COUNT;
							found = 1'b1;
						end
					end
					if (!found)
						e.status = ST_EMPTY;
				end
				default: begin
					e.status = ST_IGNORED;
				end
			endcase
			for (int i = 0; i < MASK_N; i++)
				e.pending_mask[i] = pending[i];
			awaited_rsps.push_back(e);
		endfunction

		function void check_result(ptts_rsp_t a);
			ptts_rsp_t e;
			if (awaited_rsps.size() == 0) begin
				$error("result with no command waiting: %h", a);
				mismatches++;
				return;
			end
			e = awaited_rsps.pop_front();
			if (a.status !== e.status) begin
				$error("status: expected %0d, actual %0d", e.status, a.status);
				mismatches++;
			end
			if (a.chosen_task !== e.chosen_task) begin
				$error("chosen_task: expected %0d, actual %0d", e.chosen_task, a.chosen_task);
				mismatches++;
			end
			if (a.due_mask !== e.due_mask) begin
				$error("due_mask: expected %h, actual %h", e.due_mask, a.due_mask);
				mismatches++;
			end
			if (a.pending_mask !== e.pending_mask) begin
				$error("pending_mask: expected %h, actual %h", e.pending_mask, a.pending_mask);
				mismatches++;
			end
		endfunction

	endclass

endpackage

// ===== bench/testbench.sv =====
// Top-level bench of periodic_task_tick_scheduler_unit: directed then random commands
// with random gaps and stalls, results checked by slot_table_tracker.
// Depends on ptts_pkg, ptts_slot_tracker_pkg and the scheduler RTL.
`timescale 1ns / 100ps

module testbench;

	import ptts_pkg::*;
	import ptts_slot_tracker_pkg::*;

	localparam logic [2:0] CMD_RSVD_A = 3'd6;
	localparam logic [2:0] CMD_RSVD_B = 3'd7;
	localparam int RANDOM_CMDS = 850;
	localparam int STALL_LIMIT = 3000;
	localparam int LONG_HOLD = 200;

	logic      clk = 1'b0;
	logic      arst_n;
	logic      req_valid;
	logic      req_ready;
	ptts_req_t req;
	logic      rsp_valid;
	logic      rsp_ready;
	ptts_rsp_t rsp;

	slot_table_tracker tracker;
	int send_run;
	int recv_run;
	int idle_cycles;

	periodic_task_tick_scheduler_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// random wait, with occasional back-to-back runs
	function automatic int draw_wait(ref int run_left);
		if (run_left > 0) begin
			run_left--;
			return 0;
		end
		if ($urandom_range(0, 15) == 0) begin
			run_left = $urandom_range(10, 40);
			return 0;
		end
		return $urandom_range(0, 9);
	endfunction

	task automatic send_request(input ptts_req_t c);
		int gap;
		gap = draw_wait(send_run);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req <= c;
		do @(posedge clk); while (!(req_valid && req_ready));
	endtask

	task automatic send_cmd(input logic [2:0] cmd, input logic [2:0] id, input logic [15:0] per);
		ptts_req_t c;
		c.cmd = cmd;
		c.task_id = id;
		c.period = per;
		send_request(c);
	endtask

	function automatic ptts_req_t random_command();
		ptts_req_t   c;
		int unsigned pick;
		c.task_id = 3'($urandom_range(0, 7));
		pick = $urandom_range(0, 9);
		if (pick < 7)
			c.period = 16'($urandom_range(0, 6));
		else if (pick < 9)
			c.period = 16'($urandom_range(0, 40));
		else
			c.period = 16'($urandom());
		pick = $urandom_range(0, 99);
		if (pick < 2)
			c.cmd = CMD_INIT;
		else if (pick < 14)
			c.cmd = CMD_CREATE;
		else if (pick < 44)
			c.cmd = CMD_TICK;
		else if (pick < 56)
			c.cmd = CMD_WAKE;
		else if (pick < 66)
			c.cmd = CMD_SLEEP;
		else if (pick < 97)
			c.cmd = CMD_DISPATCH;
		else
			c.cmd = ($urandom_range(0, 1) == 0) ? CMD_RSVD_A : CMD_RSVD_B;
		return c;
	endfunction

	// accepted items on both channels
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_valid && rsp_ready)
				tracker.check_result(rsp);
			if (req_valid && req_ready)
				tracker.note_command(req);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// result side; one long hold-off to back up the request side
	initial begin
		int stall;
		int taken;
		bit held;
		rsp_ready <= 1'b0;
		recv_run = 0;
		taken = 0;
		held = 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			if (!held && taken >= 300) begin
				stall = LONG_HOLD;
				held = 1'b1;
			end else begin
				stall = draw_wait(recv_run);
			end
			if (stall > 0) begin
				rsp_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ready <= 1'b1;
			do @(posedge clk); while (!(rsp_valid && rsp_ready));
			taken++;
		end
	end

	initial begin
		tracker = new();
		tracker.clear_slots();
		send_run = 0;
		idle_cycles = 0;
		arst_n <= 1'b0;
		req_valid <= 1'b0;
		req <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_cmd(CMD_TICK, 3'd0, 16'd0);
		send_cmd(CMD_DISPATCH, 3'd0, 16'd0);
		send_cmd(CMD_CREATE, 3'd0, 16'd0);
		send_cmd(CMD_CREATE, 3'd7, 16'hFFFF);
		send_cmd(CMD_CREATE, 3'd3, 16'd1);
		send_cmd(CMD_CREATE, 3'd5, 16'd2);
		send_cmd(CMD_CREATE, 3'd0, 16'd5);
		send_cmd(CMD_WAKE, 3'd6, 16'd0);
		send_cmd(CMD_SLEEP, 3'd6, 16'd0);
		send_cmd(CMD_WAKE, 3'd7, 16'd0);
		send_cmd(CMD_TICK, 3'd0, 16'd0);
		send_cmd(CMD_TICK, 3'd0, 16'd0);
		send_cmd(CMD_DISPATCH, 3'd0, 16'd0);
		send_cmd(CMD_DISPATCH, 3'd0, 16'd0);
		send_cmd(CMD_DISPATCH, 3'd0, 16'd0);
		send_cmd(CMD_DISPATCH, 3'd0, 16'd0);
		send_cmd(CMD_RSVD_A, 3'd2, 16'd9);
		send_cmd(CMD_RSVD_B, 3'd7, 16'hFFFF);
		send_cmd(CMD_WAKE, 3'd3, 16'd0);
		send_cmd(CMD_SLEEP, 3'd3, 16'd0);
		send_cmd(CMD_DISPATCH, 3'd0, 16'd0);
		send_cmd(CMD_INIT, 3'd0, 16'd0);
		send_cmd(CMD_DISPATCH, 3'd0, 16'd0);
		send_cmd(CMD_WAKE, 3'd0, 16'd0);

		for (int n = 0; n < RANDOM_CMDS; n++)
			send_request(random_command());
		req_valid <= 1'b0;

		while (tracker.awaited_rsps.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (tracker.mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/ptts_pkg.sv
rtl/ptts_rr_pick.sv
rtl/ptts_slot_table.sv
rtl/periodic_task_tick_scheduler_unit.sv
rtl/ptts_checker.sv
bench/ptts_slot_tracker_pkg.sv
bench/testbench.sv
